// ----- rtl/line_assembler_with_idle_timeout_defines.svh -----
// ----------------------------------------------------------------------------
// line_assembler_with_idle_timeout_defines.svh
// Assertion macros used by the line assembler RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_ASSEMBLER_WITH_IDLE_TIMEOUT_DEFINES_SVH
`define LINE_ASSEMBLER_WITH_IDLE_TIMEOUT_DEFINES_SVH

// check a same-cycle implication
`define LAT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a next-cycle implication
`define LAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lat_pkg.sv -----
// ----------------------------------------------------------------------------
// lat_pkg
// Types and constants of the line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned IDLE_W    = 10;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [CHAR_W-1:0] CHR_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CHR_LF   = 8'h0A;
    localparam logic [IDLE_W-1:0] IDLE_MAX = 10'd1023;

    localparam logic [CHAR_W-1:0] LINE_CAPACITY_RST = 8'd64;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST    = 10'd200;

    localparam logic REG_LINE_CAPACITY = 1'b0;
    localparam logic REG_IDLE_LIMIT    = 1'b1;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] line_capacity;
        logic [IDLE_W-1:0] idle_limit;
    } lat_cfg_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_index;
        logic [CHAR_W-1:0] char_value;
        logic              line_done;
        logic              line_ok;
        logic [CHAR_W-1:0] line_length;
    } lat_result_t;

endpackage

`default_nettype wire

// ----- rtl/lat_in_if.sv -----
// ----------------------------------------------------------------------------
// lat_in_if
// Input word channel: received byte or time tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface lat_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_value;

    modport source (output valid, output mode, output byte_value, input ready);
    modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/lat_out_if.sv -----
// ----------------------------------------------------------------------------
// lat_out_if
// Result word channel: accepted character and line end report.
// ----------------------------------------------------------------------------
`default_nettype none

interface lat_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] char_index;
    logic [7:0] char_value;
    logic       line_done;
    logic       line_ok;
    logic [7:0] line_length;

    modport source (output valid, output char_valid, output char_index, output char_value,
                    output line_done, output line_ok, output line_length, input ready);
    modport sink   (input valid, input char_valid, input char_index, input char_value,
                    input line_done, input line_ok, input line_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/line_assembler_with_idle_timeout.sv -----
// The result word of an accepted input word is registered and shows in the cycle after.
// Throughput: one word per cycle; the result register frees as it is taken.
// A stalled result holds the input off only until the sink takes it.
// Reset: asynchronous, active low; clears line state, result valid and
// restores line capacity 64 and idle limit 200.
// ----------------------------------------------------------------------------
// line_assembler_with_idle_timeout
// Assembles received bytes into lines with an idle tick timeout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_assembler_with_idle_timeout_defines.svh"

module line_assembler_with_idle_timeout
    import lat_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    lat_in_if.sink                  in_ch,
    lat_out_if.source               out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

    lat_cfg_t          cfg;

    logic              discarding_reg, discarding_next;
    logic [CHAR_W-1:0] char_count_reg, char_count_next;
    logic [IDLE_W-1:0] idle_ticks_reg, idle_ticks_next;
    logic              res_valid_reg;
    lat_result_t       res_reg, res_next;

    logic              in_fire;
    logic              term;
    logic [IDLE_W-1:0] idle_inc;

    lat_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ch.ready = !res_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign term        = (in_ch.byte_value == CHR_CR) || (in_ch.byte_value == CHR_LF);
    assign idle_inc    = (idle_ticks_reg == IDLE_MAX) ? idle_ticks_reg
                                                      : idle_ticks_reg + 1'b1;

    always_comb
    begin
        discarding_next = discarding_reg;
        char_count_next = char_count_reg;
        idle_ticks_next = idle_ticks_reg;
        res_next        = '0;
        if (in_ch.mode == MODE_TICK)
        begin
            if (discarding_reg || (char_count_reg != '0))
            begin
                idle_ticks_next = idle_inc;
                if (idle_inc >= cfg.idle_limit)
                begin
                    res_next.line_done  = 1'b1;
                    res_next.line_ok    = !discarding_reg;
                    res_next.line_length = discarding_reg ? '0 : char_count_reg;
                    discarding_next = 1'b0;
                    char_count_next = '0;
                    idle_ticks_next = '0;
                end
            end
        end
        else
        begin
            idle_ticks_next = '0;
            priority if (discarding_reg)
            begin
                if (term)
                begin
                    res_next.line_done = 1'b1;
                    discarding_next    = 1'b0;
                    char_count_next    = '0;
                end
            end
            else if ((in_ch.byte_value == CHR_LF) && (char_count_reg == '0))
            begin
                // skip a line feed with no line under way
            end
            else if (term)
            begin
                res_next.line_done   = 1'b1;
                res_next.line_ok     = 1'b1;
                res_next.line_length = char_count_reg;
                char_count_next      = '0;
            end
            else if (({1'b0, char_count_reg} + 9'd1) < {1'b0, cfg.line_capacity})
            begin
                res_next.char_valid = 1'b1;
                res_next.char_index = char_count_reg;
                res_next.char_value = in_ch.byte_value;
                char_count_next     = char_count_reg + 1'b1;
            end
            else
            begin
                discarding_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discarding_reg <= 1'b0;
            char_count_reg <= '0;
            idle_ticks_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                discarding_reg <= discarding_next;
                char_count_reg <= char_count_next;
                idle_ticks_reg <= idle_ticks_next;
            end
            if (in_ch.ready)
            begin
                res_valid_reg <= in_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.char_valid  = res_reg.char_valid;
    assign out_ch.char_index  = res_reg.char_index;
    assign out_ch.char_value  = res_reg.char_value;
    assign out_ch.line_done   = res_reg.line_done;
    assign out_ch.line_ok     = res_reg.line_ok;
    assign out_ch.line_length = res_reg.line_length;

    `LAT_ASSERT_NEXT(a_fire_gives_result, in_fire, res_valid_reg, "accepted word lost its result")
    `LAT_ASSERT_IMPL(a_char_xor_done, res_valid_reg && res_reg.char_valid, !res_reg.line_done, "character and line end in one word")
    `LAT_ASSERT_IMPL(a_reject_zero_len, res_valid_reg && !res_reg.line_ok, res_reg.line_length == '0, "rejected line with nonzero length")
    `LAT_ASSERT_NEXT(a_byte_clears_idle, in_fire && (in_ch.mode == MODE_BYTE), idle_ticks_reg == '0, "received byte left idle count")

endmodule

`default_nettype wire

// ----- rtl/lat_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lat_cfg_regs
// APB register file for line capacity and idle limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_cfg_regs
    import lat_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready,
    output      lat_cfg_t           cfg
);

    lat_cfg_t cfg_reg;
    logic     wr_en;
    logic     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_capacity <= LINE_CAPACITY_RST;
            cfg_reg.idle_limit    <= IDLE_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LINE_CAPACITY: cfg_reg.line_capacity <= pwdata[CHAR_W-1:0];
                REG_IDLE_LIMIT:    cfg_reg.idle_limit    <= pwdata[IDLE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LINE_CAPACITY: prdata = {{(PDATA_W-CHAR_W){1'b0}}, cfg_reg.line_capacity};
            REG_IDLE_LIMIT:    prdata = {{(PDATA_W-IDLE_W){1'b0}}, cfg_reg.idle_limit};
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- test/lat_line_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lat_line_checker
// Watches the byte/tick channel, the result channel and the register port of
// the line assembler. It keeps its own copy of the line state and the
// settings, predicts the result word of every accepted input word and
// compares the result words in order, field by field.
// ----------------------------------------------------------------------------
module lat_line_checker
    import lat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lat_in_if                  in_ch,
    lat_out_if                 out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 pending_count
);

    logic [CHAR_W-1:0] capacity_q;
    logic [IDLE_W-1:0] idle_limit_q;
    logic              discarding_q;
    logic [CHAR_W-1:0] char_count_q;
    logic [IDLE_W-1:0] idle_ticks_q;
    lat_result_t       expected_words[$];
    int                mismatches = 0;

    function automatic lat_result_t assemble_word(input logic m, input logic [CHAR_W-1:0] b);
        lat_result_t r;
        logic        term;
        logic        closes;
        r      = '0;
        closes = 1'b0;
        term   = (b == CHR_CR) || (b == CHR_LF);
        if (m == MODE_TICK)
        begin
            if (discarding_q || char_count_q != '0)
            begin
                if (idle_ticks_q != IDLE_MAX)
                    idle_ticks_q = idle_ticks_q + 1'b1;
                closes = (idle_ticks_q >= idle_limit_q);
            end
        end
        else
        begin
            idle_ticks_q = '0;
            if (discarding_q)
                closes = term;
            else if (!(b == CHR_LF && char_count_q == '0))
            begin
                if (term)
                    closes = 1'b1;
                else if ({1'b0, char_count_q} + 9'd1 < {1'b0, capacity_q})
                begin
                    r.char_valid = 1'b1;
                    r.char_index = char_count_q;
                    r.char_value = b;
                    char_count_q = char_count_q + 1'b1;
                end
                else
                    discarding_q = 1'b1;
            end
        end
        if (closes)
        begin
            r.line_done   = 1'b1;
            r.line_ok     = !discarding_q;
            r.line_length = discarding_q ? '0 : char_count_q;
            discarding_q  = 1'b0;
            char_count_q  = '0;
            idle_ticks_q  = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lat_result_t want;
        if (!rst_n)
        begin
            capacity_q   = LINE_CAPACITY_RST;
            idle_limit_q = IDLE_LIMIT_RST;
            discarding_q = 1'b0;
            char_count_q = '0;
            idle_ticks_q = '0;
            expected_words.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_LINE_CAPACITY: capacity_q   = pwdata[CHAR_W-1:0];
                    REG_IDLE_LIMIT:    idle_limit_q = pwdata[IDLE_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no input word waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("char_valid", int'(want.char_valid), int'(out_ch.char_valid));
                    check_field("char_index", int'(want.char_index), int'(out_ch.char_index));
                    check_field("char_value", int'(want.char_value), int'(out_ch.char_value));
                    check_field("line_done", int'(want.line_done), int'(out_ch.line_done));
                    check_field("line_ok", int'(want.line_ok), int'(out_ch.line_ok));
                    check_field("line_length", int'(want.line_length),
                                int'(out_ch.line_length));
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(assemble_word(in_ch.mode, in_ch.byte_value));
        end
        fail_count    <= mismatches;
        pending_count <= expected_words.size();
    end

endmodule

// ----- test/line_assembler_with_idle_timeout_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_assembler_with_idle_timeout_tb
// Feeds the line assembler with received bytes and time ticks: a directed
// run over empty lines, terminators, zero and one capacity and timeouts,
// then random lines under several capacity and idle limit settings, with
// random gaps on the input and random stalls on the result side. A checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module line_assembler_with_idle_timeout_tb;
    import lat_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending_count;
    int quiet_cycles = 0;
    int line_cap     = 64;
    int tick_limit   = 200;
    bit gaps_on      = 1'b0;
    bit stalls_on    = 1'b0;

    lat_in_if  in_ch();
    lat_out_if out_ch();

    line_assembler_with_idle_timeout dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lat_line_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 94)
            return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    task automatic push_word(input logic m, input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.byte_value <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic send_tick();
        push_word(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHR_CR || b == CHR_LF)
            b = 8'($urandom_range(0, 255));
        push_word(MODE_BYTE, b);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int cap, input int lim);
        drain();
        write_reg(REG_LINE_CAPACITY, cap);
        write_reg(REG_IDLE_LIMIT, lim);
        line_cap   = cap;
        tick_limit = lim;
    endtask

    task automatic send_line(input int len);
        int ticks;
        for (int i = 0; i < len; i++)
        begin
            send_text_byte();
            if (tick_limit > 1 && $urandom_range(0, 6) == 0)
            begin
                ticks = $urandom_range(1, (tick_limit > 4) ? 3 : tick_limit - 1);
                repeat (ticks) send_tick();
            end
        end
        case ($urandom_range(0, 2))
            0: push_word(MODE_BYTE, CHR_CR);
            1: push_word(MODE_BYTE, CHR_LF);
            default:
                if (tick_limit <= 40)
                    repeat ((tick_limit == 0) ? 1 : tick_limit) send_tick();
                else
                    push_word(MODE_BYTE, CHR_CR);
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 3))
                0: send_tick();
                1: push_word(MODE_BYTE, ($urandom_range(0, 1) != 0) ? CHR_CR : CHR_LF);
                default: push_word(MODE_BYTE, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic run_phase(input int cap, input int lim, input int lines, input int maxlen);
        configure(cap, lim);
        repeat (lines)
        begin
            if ($urandom_range(0, 9) < 8)
                send_line($urandom_range(0, maxlen));
            else
                send_noise();
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap_length()) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("line_assembler_with_idle_timeout test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_BYTE;
        in_ch.byte_value = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // skipped line feed, ignored tick, empty line, then short lines
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        push_word(MODE_BYTE, CHR_LF);
        send_tick();
        push_word(MODE_BYTE, CHR_CR);
        push_word(MODE_BYTE, 8'h00);
        push_word(MODE_BYTE, 8'hFF);
        push_word(MODE_BYTE, 8'h41);
        send_tick();
        push_word(MODE_BYTE, CHR_CR);
        push_word(MODE_BYTE, 8'h7E);
        push_word(MODE_BYTE, CHR_LF);

        // no room at all, first tick ends the discard
        configure(0, 0);
        push_word(MODE_BYTE, 8'h61);
        send_tick();
        push_word(MODE_BYTE, 8'h62);
        push_word(MODE_BYTE, CHR_LF);

        configure(1, 1023);
        push_word(MODE_BYTE, 8'h71);
        push_word(MODE_BYTE, 8'h72);
        push_word(MODE_BYTE, CHR_CR);

        // overflow then timeout, partial line timeout, idle ticks
        configure(3, 2);
        push_word(MODE_BYTE, 8'h61);
        push_word(MODE_BYTE, 8'h62);
        push_word(MODE_BYTE, 8'h63);
        send_tick();
        send_tick();
        push_word(MODE_BYTE, 8'h64);
        send_tick();
        send_tick();
        send_tick();

        // full capacity line running into discard
        configure(255, 1023);
        repeat (256) send_text_byte();
        push_word(MODE_BYTE, CHR_CR);
        run_phase(255, 1023, 15, 12);

        run_phase(0, 1, 20, 3);

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_phase(1, 3, 20, 3);

        stalls_on = 1'b1;
        run_phase(2, 2, 25, 4);

        gaps_on   = 1'b1;
        stalls_on = 1'b0;
        run_phase(10, 6, 25, 12);

        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        line_cap  = $urandom_range(3, 40);
        run_phase(line_cap, $urandom_range(1, 30), 12, line_cap + 2);

        // long idle run up to a large limit
        gaps_on = 1'b1;
        configure(5, 300);
        repeat (3) send_text_byte();
        repeat (300) send_tick();
        run_phase(5, 300, 10, 6);

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("line_assembler_with_idle_timeout test passed");
        else
            $display("line_assembler_with_idle_timeout test failed");
        $finish;
    end

endmodule
